@@ sv/ssh_pkg.sv @@
// Shared types, round constants and mixing functions for the SHA-256 hasher.
// No dependencies.
package ssh_pkg;

    localparam int FrontDepth = 2;
    localparam int OutDepth   = 8;

    typedef struct packed {
        logic [31:0] word;   // full word, or masked short word with 0x80 appended
        logic [2:0]  n;      // clamped byte count
        logic        fin;    // finishes the message
    } cmd_t;

    localparam logic [31:0] PadWord = 32'h8000_0000;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] j);
        logic [31:0] t [64];
        t = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = t[j];
    endfunction

endpackage

@@ sv/ssh_front.sv @@
// Front end: classifies incoming words and holds them in a two-entry queue.
// Depends on ssh_pkg.
module ssh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        data_word,
    input  logic [2:0]         byte_count,
    input  logic               last,
    output logic               cmd_valid,
    output ssh_pkg::cmd_t      cmd,
    input  logic               cmd_pop
);
    import ssh_pkg::*;

    cmd_t        q_reg [FrontDepth];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [2:0]  n;
    logic        fin, keep;
    logic [31:0] mask, pad;
    cmd_t        c;

    always_comb
    begin
        n    = (byte_count > 3'd4) ? 3'd4 : byte_count;
        fin  = last || (n != 3'd4 && n != 3'd0);
        keep = fin || (n == 3'd4);
        mask = (n == 3'd0) ? 32'h0 : (32'hffff_ffff << (6'd32 - {n, 3'b000}));
        pad  = 32'h80 << (5'd24 - {n[1:0], 3'b000});
        c.n   = n;
        c.fin = fin;
        c.word = (n == 3'd4) ? data_word : ((data_word & mask) | pad);
    end

    assign full      = (cnt_reg == 2'(FrontDepth));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Drop empty words that do not finish the message.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full && keep)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (cmd_pop && cmd_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push && !full && keep) - 2'(cmd_pop && cmd_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full && keep)
            q_reg[wr_ptr_reg] <= c;
    end

endmodule

@@ sv/ssh_back.sv @@
// Back end: block buffer, padding sequencer, round engine and digest queue.
// Depends on ssh_pkg.
module ssh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  ssh_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               final_word
);
    import ssh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_SEQ = 3'd1, S_COMP = 3'd2, S_ADD = 3'd3,
                           S_OUT = 3'd4;
    localparam logic [2:0] PH_NONE = 3'd0, PH_DATA = 3'd1, PH_PAD1 = 3'd2, PH_ZERO = 3'd3,
                           PH_LENLO = 3'd4, PH_DONE = 3'd5;

    logic [2:0]  state_reg, ph_reg;
    logic [3:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  k_reg;
    logic [63:0] bytes_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] s_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] word_reg;
    logic        n4_reg;

    logic [31:0] q_word_reg [OutDepth];
    logic [2:0]  q_idx_reg [OutDepth];
    logic [2:0]  qw_ptr_reg, qr_ptr_reg;
    logic [3:0]  qcnt_reg;
    logic        q_full, q_push, q_pop;

    logic        push_en;
    logic [31:0] push_val;
    logic [63:0] bits;
    logic [31:0] t1, t2, w_new;

    assign bits = bytes_reg << 3;

    always_comb
    begin
        push_en  = 1'b0;
        push_val = 32'h0;
        cmd_pop  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid && !cmd.fin)
                begin
                    push_en  = 1'b1;
                    push_val = cmd.word;
                end
            end
            S_SEQ:
            begin
                push_en = 1'b1;
                case (ph_reg)
                    PH_DATA:  push_val = word_reg;
                    PH_PAD1:  push_val = n4_reg ? PadWord : word_reg;
                    PH_ZERO:  push_val = (fill_reg == 4'd14) ? bits[63:32] : 32'h0;
                    PH_LENLO: push_val = bits[31:0];
                    default:  push_en = 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        t1 = s_reg[7] + bsig1(s_reg[4]) + ((s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6]))
           + round_k(rnd_reg) + w_reg[0];
        t2 = bsig0(s_reg[0])
           + ((s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
        w_new = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];
    end

    assign q_full = (qcnt_reg == 4'(OutDepth));
    assign q_push = (state_reg == S_OUT) && !q_full;
    assign q_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_NONE;
            fill_reg  <= 4'd0;
            rnd_reg   <= 6'd0;
            k_reg     <= 3'd0;
            bytes_reg <= 64'd0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            if (push_en)
                fill_reg <= fill_reg + 4'd1;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        bytes_reg <= bytes_reg + 64'(cmd.n);
                        if (cmd.fin)
                        begin
                            state_reg <= S_SEQ;
                            ph_reg    <= (cmd.n == 3'd4) ? PH_DATA : PH_PAD1;
                        end
                    end
                end
                S_SEQ:
                begin
                    case (ph_reg)
                        PH_DATA:  ph_reg <= PH_PAD1;
                        PH_PAD1:  ph_reg <= PH_ZERO;
                        PH_ZERO:  if (fill_reg == 4'd14) ph_reg <= PH_LENLO;
                        default:  ph_reg <= PH_DONE;
                    endcase
                end
                S_COMP:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + s_reg[i];
                    if (ph_reg == PH_DONE)
                        state_reg <= S_OUT;
                    else if (ph_reg == PH_NONE)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_SEQ;
                end
                S_OUT:
                begin
                    if (!q_full)
                    begin
                        k_reg <= k_reg + 3'd1;
                        // Re-initialise once H7 is queued.
                        if (k_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= init_hash(3'(i));
                            bytes_reg <= 64'd0;
                            ph_reg    <= PH_NONE;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // A push into the last slot starts compression.
            if (push_en && fill_reg == 4'd15)
            begin
                state_reg <= S_COMP;
                rnd_reg   <= 6'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            word_reg <= cmd.word;
            n4_reg   <= (cmd.n == 3'd4);
        end
        if (push_en)
            w_reg[fill_reg] <= push_val;
        if (push_en && fill_reg == 4'd15)
        begin
            for (int i = 0; i < 8; i++)
                s_reg[i] <= hash_reg[i];
        end
        if (state_reg == S_COMP)
        begin
            // Slide the schedule window and advance one round.
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            for (int i = 1; i < 8; i++)
                s_reg[i] <= s_reg[i - 1];
            s_reg[4] <= s_reg[3] + t1;
            s_reg[0] <= t1 + t2;
        end
        if (q_push)
        begin
            q_word_reg[qw_ptr_reg] <= hash_reg[k_reg];
            q_idx_reg[qw_ptr_reg]  <= k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_ptr_reg <= 3'd0;
            qr_ptr_reg <= 3'd0;
            qcnt_reg   <= 4'd0;
        end
        else
        begin
            if (q_push)
                qw_ptr_reg <= qw_ptr_reg + 3'd1;
            if (q_pop)
                qr_ptr_reg <= qr_ptr_reg + 3'd1;
            qcnt_reg <= qcnt_reg + 4'(q_push) - 4'(q_pop);
        end
    end

    assign empty       = (qcnt_reg == 4'd0);
    assign digest_word = q_word_reg[qr_ptr_reg];
    assign word_index  = q_idx_reg[qr_ptr_reg];
    assign final_word  = (q_idx_reg[qr_ptr_reg] == 3'd7);

    a_comp_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) |-> (fill_reg == 4'd0))
        else $error("block buffer not empty during rounds");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (ph_reg == PH_DONE))
        else $error("digest output without finished padding");
    a_qcnt: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= 4'(OutDepth))
        else $error("digest queue overflow");
    a_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd_pop)
        else $error("command taken while busy");

endmodule

@@ sv/sha256_stream_hasher.sv @@
// SHA-256 stream hasher: front queue and compression back end.
// Back-end work: a word that fills a block starts compression (64 rounds, then the add);
// a finishing word adds up to 2 padding blocks plus eight digest words of output.
// Throughput is set by the one-round-per-cycle engine: the back end takes no words then.
// Reset: asynchronous, active low; queues empty, hash words at the initial values.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        final_word
);
    import ssh_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_pop;

    ssh_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_word(data_word), .byte_count(byte_count), .last(last),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    ssh_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .final_word(final_word)
    );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the SHA-256 stream hasher: directed, hold-off and random tests.
// Depends on sha256_stream_hasher (sv/) only; carries its own SHA-256 digest predictor.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        lst;
        logic        chk;    // typed digest given for word 0
        logic [31:0] h0;
    } stim_row_t;

    typedef struct {
        logic [31:0] dig;
        logic [2:0]  idx;
        logic        fin;
        logic        chk;
        logic [31:0] typed;
    } digest_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [31:0] data_word = '0;
    logic [2:0]  byte_count = '0;
    logic        last = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    digest_exp_t digest_q [$];
    int          errors = 0;
    bit          hold_pop = 1'b0;

    logic [31:0] hw [8];
    logic [31:0] bw [16];
    logic [63:0] msg_bytes;
    int          fill;

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    sha256_stream_hasher u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_word(data_word), .byte_count(byte_count), .last(last),
        .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .final_word(final_word)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = bw[j];
        for (int j = 16; j < 64; j++)
            w[j] = (ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10)) + w[j-7]
                 + (ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3)) + w[j-16];
        s = hw;
        for (int j = 0; j < 64; j++)
        begin
            t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + KTAB[j] + w[j];
            t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hw[j] += s[j];
    endtask

    task automatic load_word(input logic [31:0] v);
        bw[fill] = v;
        fill++;
        if (fill == 16)
        begin
            compress_block();
            fill = 0;
        end
    endtask

    task automatic hasher_reset();
        hw = IV;
        msg_bytes = '0;
        fill = 0;
    endtask

    // Advance the predictor by one accepted word; queue eight digest words on a finish.
    task automatic predict_digest(input logic [31:0] d, input logic [2:0] c, input logic l,
                                  input logic chk, input logic [31:0] h0);
        int          n;
        logic        fin;
        logic [31:0] mask;
        logic [63:0] bits;
        digest_exp_t e;
        n = (c > 3'd4) ? 4 : int'(c);
        fin = l || (n > 0 && n < 4);
        if (!fin)
        begin
            if (n == 4)
            begin
                msg_bytes += 4;
                load_word(d);
            end
            return;
        end
        msg_bytes += n;
        if (n == 4)
        begin
            load_word(d);
            load_word(32'h8000_0000);
        end
        else
        begin
            mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
            load_word((d & mask) | (32'h80 << (24 - 8 * n)));
        end
        if (fill > 14)
            while (fill != 0)
                load_word(32'h0);
        while (fill < 14)
            load_word(32'h0);
        bits = msg_bytes << 3;
        load_word(bits[63:32]);
        load_word(bits[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            e.dig = hw[k];
            e.idx = 3'(k);
            e.fin = (k == 7);
            e.chk = chk && (k == 0);
            e.typed = h0;
            digest_q.push_back(e);
        end
        hasher_reset();
    endtask

    // Hold push high across back-to-back words; drop it only before an idle gap.
    task automatic send_word(input logic [31:0] d, input logic [2:0] c, input logic l,
                             input logic chk, input logic [31:0] h0, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        push <= 1'b1;
        data_word <= d;
        byte_count <= c;
        last <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_digest(d, c, l, chk, h0);
    endtask

    task automatic drain_digests();
        push <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (hold_pop || gap != 0)
            begin
                pop <= 1'b0;
                if (hold_pop)
                begin
                    repeat (600)
                        @(posedge clk);
                    hold_pop = 1'b0;
                end
                repeat (gap)
                    @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        digest_exp_t e;
        if (rst_n && pop && !empty)
        begin
            if (digest_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digest word %h idx %0d", digest_word, word_index);
            end
            else
            begin
                e = digest_q.pop_front();
                if (digest_word !== e.dig || word_index !== e.idx || final_word !== e.fin
                    || (e.chk && digest_word !== e.typed))
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", e.dig, e.idx,
                                 e.fin, digest_word, word_index, final_word);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        int        len;
        logic [2:0] c;
        hasher_reset();
        // Empty message, "abc", bytes past the count, short non-last word, idle
        // empty word, count above four, extremes of the data field.
        rows.push_back('{32'h0, 3'd0, 1'b1, 1'b1, 32'he3b0c442});
        rows.push_back('{32'h616263ff, 3'd3, 1'b1, 1'b1, 32'hba7816bf});
        rows.push_back('{32'h61626300, 3'd3, 1'b0, 1'b1, 32'hba7816bf});
        rows.push_back('{32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0});
        rows.push_back('{32'hffffffff, 3'd7, 1'b0, 1'b0, 32'h0});
        rows.push_back('{32'h00000000, 3'd5, 1'b0, 1'b0, 32'h0});
        rows.push_back('{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0});
        rows.push_back('{32'h12345678, 3'd1, 1'b1, 1'b0, 32'h0});
        rows.push_back('{32'hdeadbeef, 3'd2, 1'b1, 1'b0, 32'h0});
        rows.push_back('{32'haaaa5555, 3'd6, 1'b1, 1'b0, 32'h0});
        for (int i = 0; i < 14; i++)
            rows.push_back('{32'h5555aaaa ^ i, 3'd4, 1'b0, 1'b0, 32'h0});
        rows.push_back('{32'h0, 3'd0, 1'b1, 1'b0, 32'h0});
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_word(rows[i].data, rows[i].cnt, rows[i].lst, rows[i].chk, rows[i].h0, 0);
        // Sender pause until all digests are back.
        drain_digests();
        // Receiver holds off while the sender keeps offering a long message, then one-byte messages.
        hold_pop = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word($urandom, 3'd4, 1'b0, 1'b0, 32'h0, 1);
        send_word($urandom, 3'd4, 1'b1, 1'b0, 32'h0, 1);
        for (int i = 0; i < 18; i++)
            send_word($urandom, 3'd1, 1'b1, 1'b0, 32'h0, 1);
        // Random messages, mostly well formed, short or with lengths around the padding boundaries.
        for (int m = 0; m < 16; m++)
        begin
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4)
                                              : $urandom_range(12, 17);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              1'b0, 32'h0, 0);
                else
                    send_word($urandom, 3'd4, 1'b0, 1'b0, 32'h0, 0);
            end
            c = 3'($urandom_range(0, 7));
            send_word($urandom, c, 1'b1, 1'b0, 32'h0, 0);
        end
        drain_digests();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
